// ----- rtl/tdes_pkg.sv -----
`timescale 1ns / 1ps
package tdes_pkg;

  localparam int unsigned NumRounds = 48;
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegFirstKey = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSecondKey = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThirdKey = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDecryptMode = 2'd3;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  // cumulative left shift of C and D before round i
  localparam logic [4:0] TabShift [16] = '{1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};
  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
    logic        last;
  } round_data_t;

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = x[64-TabIp[i]];
    return o;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = x[64-TabFp[i]];
    return o;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = x[64-TabPc1[i]];
    return o;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [4:0] s);
    logic [55:0] d;
    d = {v, v} << s;
    return d[55:28];
  endfunction

  // round key i (0..15) from a key, rotation folded in as a fixed wiring
  function automatic logic [47:0] subkey(input logic [63:0] key, input logic [3:0] idx);
    logic [55:0] cd;
    logic [55:0] rc;
    logic [47:0] o;
    cd = perm_pc1(key);
    rc = {rot28(cd[55:28], TabShift[idx]), rot28(cd[27:0], TabShift[idx])};
    for (int i = 0; i < 48; i++) o[47-i] = rc[56-TabPc2[i]];
    return o;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] o;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-TabE[i]];
    e = e ^ k;
    for (int b = 0; b < 8; b++) begin
      six = e[47-6*b -: 6];
      s[31-4*b -: 4] = TabS[b][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = s[32-TabP[i]];
    return o;
  endfunction

endpackage

// ----- rtl/triple_des_ecb_cipher_unit.sv -----
`timescale 1ns / 1ps
// Triple DES (EDE) ECB cipher, 48-round pipeline.
// Input channel: in_valid/in_stall with block_in and last_block; a beat moves
// when valid is high and stall is low. Output channel: out_valid/out_stall with
// block_out and last_block_out, same rule.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 first_key, 1 second_key,
// 2 third_key, 3 decrypt_mode) and cfg_data; cfg_ready is always high. Other
// indexes are dropped. Write only while the pipe is empty; after the last write the
// round keys settle through the subkey registers, then the round-key registers.
// Throughput: one block per cycle while out_stall does not hold the pipe. Each DES
// round has its own register, with the final one serving as the output register.
// Reset clears every stage valid bit and all config registers to zero keys, encrypt;
// the round keys for the zero keys are ready at once.
// When a finished beat waits with out_stall high the whole pipe holds and
// in_stall is high; empty stages are not squeezed out, so no beat is lost
// or repeated.
module triple_des_ecb_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] block_in,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] block_out,
  output logic        last_block_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int unsigned N = tdes_pkg::NumRounds;

  logic [63:0] first_key;
  logic [63:0] second_key;
  logic [63:0] third_key;
  logic        decrypt_mode;
  logic [47:0] round_keys [N];
  logic                  stage_valid [N];
  tdes_pkg::round_data_t stage_data [N];
  tdes_pkg::round_data_t head;
  logic [63:0] ip_out;
  logic        advance;
  logic        hit;

  assign cfg_ready = 1'b1;
  assign hit = cfg_index[63:tdes_pkg::CfgIdxW] == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_key <= '0;
      second_key <= '0;
      third_key <= '0;
      decrypt_mode <= 1'b0;
    end else if (cfg_valid && hit) begin
      case (cfg_index[tdes_pkg::CfgIdxW-1:0])
        tdes_pkg::RegFirstKey:    first_key <= cfg_data;
        tdes_pkg::RegSecondKey:   second_key <= cfg_data;
        tdes_pkg::RegThirdKey:    third_key <= cfg_data;
        tdes_pkg::RegDecryptMode: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tdes_key_sched u_keys (
    .clk(clk), .rst(rst), .first_key(first_key), .second_key(second_key),
    .third_key(third_key), .decrypt_mode(decrypt_mode), .round_keys(round_keys)
  );

  // advance the whole pipe unless a finished beat is blocked
  assign advance = !(stage_valid[N-1] && out_stall);
  assign in_stall = !advance;

  assign ip_out = tdes_pkg::perm_ip(block_in);
  assign head = '{l: ip_out[63:32], r: ip_out[31:0], last: last_block};

  for (genvar g = 0; g < N; g++) begin : g_round
    tdes_round u_round (
      .clk(clk), .rst(rst), .advance(advance),
      .valid_in(g == 0 ? in_valid : stage_valid[g == 0 ? 0 : g-1]),
      .data_in(g == 0 ? head : stage_data[g == 0 ? 0 : g-1]),
      .round_key(round_keys[g]),
      .swap_out((g % 16) == 15),
      .valid(stage_valid[g]), .data(stage_data[g])
    );
  end

  assign out_valid = stage_valid[N-1];
  assign block_out = tdes_pkg::perm_fp({stage_data[N-1].l, stage_data[N-1].r});
  assign last_block_out = stage_data[N-1].last;
endmodule

// ----- rtl/tdes_round.sv -----
`timescale 1ns / 1ps
// One registered DES round; pass 0..2 and round number are fixed per instance.
module tdes_round (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     valid_in,
  input  tdes_pkg::round_data_t    data_in,
  input  logic [47:0]              round_key,
  input  logic                     swap_out,
  output logic                     valid,
  output tdes_pkg::round_data_t    data
);
  logic [31:0] new_r;

  assign new_r = data_in.l ^ tdes_pkg::feistel(data_in.r, round_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
  end

  // the last round of each DES pass also undoes the L/R swap, FP then IP cancel
  always_ff @(posedge clk) begin
    if (advance) begin
      data.last <= data_in.last;
      if (swap_out) begin
        data.l <= new_r;
        data.r <= data_in.r;
      end else begin
        data.l <= data_in.r;
        data.r <= new_r;
      end
    end
  end
endmodule

// ----- rtl/tdes_key_sched.sv -----
`timescale 1ns / 1ps
// Precompute the 48 round keys in encrypt/decrypt order; the user must change keys only while idle, not enforced here.
module tdes_key_sched (
  input  logic        clk,
  input  logic        rst,
  input  logic [63:0] first_key,
  input  logic [63:0] second_key,
  input  logic [63:0] third_key,
  input  logic        decrypt_mode,
  output logic [47:0] round_keys [tdes_pkg::NumRounds]
);
  logic [47:0] k1 [16];
  logic [47:0] k2 [16];
  logic [47:0] k3 [16];

  // an all-zero key gives all-zero round keys, matching the reset key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        k1[i] <= '0;
        k2[i] <= '0;
        k3[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        k1[i] <= tdes_pkg::subkey(first_key, 4'(i));
        k2[i] <= tdes_pkg::subkey(second_key, 4'(i));
        k3[i] <= tdes_pkg::subkey(third_key, 4'(i));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tdes_pkg::NumRounds; i++) begin
        round_keys[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (decrypt_mode) begin
          round_keys[i]      <= k3[15-i];
          round_keys[16 + i] <= k2[i];
          round_keys[32 + i] <= k1[15-i];
        end else begin
          round_keys[i]      <= k1[i];
          round_keys[16 + i] <= k2[15-i];
          round_keys[32 + i] <= k3[i];
        end
      end
    end
  end
endmodule

// ----- rtl/tdes_checker.sv -----
`timescale 1ns / 1ps
module tdes_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] block_out,
  input logic        cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(block_out))
    else $error("stalled result changed");
  a_no_back: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config not ready");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind triple_des_ecb_cipher_unit tdes_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .block_out(block_out),
  .cfg_ready(cfg_ready)
);
